// ===== src/vfv_pkg.sv =====
// Shared types, widths and codes for the voxel face visibility block.
package vfv_pkg;

   localparam int VFV_MAX_EDGE = 16;   // default cube edge of the voxel store
   localparam int COORD_W      = 4;    // width of one coordinate field
   localparam int NBR_W        = COORD_W + 1;  // neighbour coordinate, room for +1 and wrap of -1
   localparam int CSR_W        = 5;    // chunk_size register width
   localparam int STEP_W       = 3;
   localparam int RSP_W        = 8;
   localparam int REQ_W        = 16;

   localparam logic [CSR_W-1:0] CHUNK_RESET = CSR_W'(16);

   // request kinds, carried on tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // neighbour probe order; the last probe is STEP_RIGHT
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TOP    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_BOTTOM = 3'd2;
   localparam logic [STEP_W-1:0] STEP_FRONT  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_BACK   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_LEFT   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_RIGHT  = 3'd6;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } pos_type;

endpackage

// ===== src/vfv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vfv_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/vfv_nbr.sv =====
// Shared neighbour unit: offsets a cell by one probe step, checks the chunk edge, forms the address.
module vfv_nbr
   import vfv_pkg::*;
#(
   parameter int MAX_EDGE = VFV_MAX_EDGE
) (
   input  pos_type                           pos,
   input  logic [STEP_W-1:0]                 step,
   input  logic [CSR_W-1:0]                  edge_len,
   output logic                              in_chunk,
   output logic [3*$clog2(MAX_EDGE)-1:0]     addr
);

   localparam int CW = $clog2(MAX_EDGE);

   logic [NBR_W-1:0] nx;
   logic [NBR_W-1:0] ny;
   logic [NBR_W-1:0] nz;

   // x-1 at zero wraps to all ones, which is never below the edge
   always_comb begin
      nx = {1'b0, pos.x};
      ny = {1'b0, pos.y};
      nz = {1'b0, pos.z};
      case (step)
         STEP_TOP:    ny = ny + NBR_W'(1);
         STEP_BOTTOM: ny = ny - NBR_W'(1);
         STEP_FRONT:  nz = nz + NBR_W'(1);
         STEP_BACK:   nz = nz - NBR_W'(1);
         STEP_LEFT:   nx = nx - NBR_W'(1);
         STEP_RIGHT:  nx = nx + NBR_W'(1);
         default: ;
      endcase
   end

   assign in_chunk = (nx < NBR_W'(edge_len)) && (ny < NBR_W'(edge_len))
                     && (nz < NBR_W'(edge_len));
   assign addr     = {CW'(nx), CW'(ny), CW'(nz)};

endmodule

// ===== src/voxel_face_visibility.sv =====
// Top level: voxel solid map with a sequencer that probes a cell and its six neighbours.
//
// Request stream (req_*): one transfer per item. tuser = 0 writes the solid bit of one
// cell, tuser = 1 queries it. A write gives no response; writes outside the chunk are
// dropped. A query gives one response transfer with in_range, cell_solid and six face
// flags (lowest bit first).
// A query runs the single read port of the map seven times (center, then top, bottom,
// front, back, left, right) through one shared neighbour unit, then passes ST_FIN and
// ST_DONE before it loads the response; req_tready stays low until then.
// Writes sustain one per cycle while the sequencer is idle.
// The response sits in an output register; when the receiver stalls, a finished query
// waits in the sequencer until that register frees, so at most two queries are in flight.
// csr_* writes chunk_size (edge of the cube in use, saturated at MAX_EDGE); always ready.
// Reset sets chunk_size to 16 and starts a clearing pass that marks every cell solid,
// one cell per cycle, over all (2**clog2(MAX_EDGE))**3 cells, 4096 at the default. req_tready
// stays low until it ends; csr writes are taken throughout.
module voxel_face_visibility
   import vfv_pkg::*;
#(
   parameter int MAX_EDGE = VFV_MAX_EDGE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // pos_x[3:0], pos_y[7:4], pos_z[11:8], solid[12], zero
   input  logic             req_tuser,   // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // in_range, cell_solid, top, bottom, front, back,
                                         // left, right
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int CW    = $clog2(MAX_EDGE);
   localparam int AW    = 3 * CW;
   localparam int DEPTH = 1 << AW;
   localparam logic [CSR_W:0] MAX_EDGE_V = (CSR_W + 1)'(MAX_EDGE);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CSR_W-1:0]   chunk_ff, chunk_in;
   pos_type            pos_ff, pos_in;
   logic               range_ff, range_in;
   logic               pend_ff, pend_in;
   logic [STEP_W-1:0]  pend_step_ff, pend_step_in;
   logic               pend_inside_ff, pend_inside_in;
   logic [6:0]         blk_ff, blk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   pos_type            req_pos;
   logic               req_solid;
   logic               req_fire;
   logic [CSR_W:0]     edge_wide;
   logic [CSR_W-1:0]   edge_len;
   pos_type            nbr_pos;
   logic [STEP_W-1:0]  nbr_step;
   logic               nbr_inside;
   logic [AW-1:0]      nbr_addr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic               mem_wdata;
   logic               mem_re;
   logic               mem_rdata;
   logic               slot_free;
   logic               cell_solid;

   assign req_pos.x = req_tdata[3:0];
   assign req_pos.y = req_tdata[7:4];
   assign req_pos.z = req_tdata[11:8];
   assign req_solid = req_tdata[12];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign edge_wide = ({1'b0, chunk_ff} > MAX_EDGE_V) ? MAX_EDGE_V : {1'b0, chunk_ff};
   assign edge_len  = edge_wide[CSR_W-1:0];

   // idle: the unit checks the incoming request; running: it walks the probes
   assign nbr_pos  = (state_ff == ST_IDLE) ? req_pos : pos_ff;
   assign nbr_step = (state_ff == ST_IDLE) ? STEP_CENTER : step_ff;

   vfv_nbr #(
      .MAX_EDGE (MAX_EDGE)
   ) u_nbr (
      .pos      (nbr_pos),
      .step     (nbr_step),
      .edge_len (edge_len),
      .in_chunk (nbr_inside),
      .addr     (nbr_addr)
   );

   assign mem_we    = (state_ff == ST_CLEAR) ||
                      (req_fire && (req_tuser == KIND_WRITE) && nbr_inside);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : nbr_addr;
   assign mem_wdata = (state_ff == ST_CLEAR) ? 1'b1 : req_solid;
   assign mem_re    = (state_ff == ST_RUN);

   vfv_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (nbr_addr),
      .rd_data (mem_rdata)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign cell_solid = range_ff && blk_ff[STEP_CENTER];

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      step_in        = step_ff;
      pos_in         = pos_ff;
      range_in       = range_ff;
      pend_in        = 1'b0;
      pend_step_in   = step_ff;
      pend_inside_in = nbr_inside;
      blk_in         = blk_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      chunk_in       = csr_valid ? csr_data : chunk_ff;

      // read data comes back in the cycle after the probe: blocked = inside and solid
      if (pend_ff) begin
         blk_in[pend_step_ff] = pend_inside_ff && mem_rdata;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_QUERY)) begin
               pos_in   = req_pos;
               range_in = nbr_inside;
               step_in  = STEP_CENTER;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            pend_in = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_RIGHT) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cell_solid && !blk_ff[STEP_RIGHT],
                               cell_solid && !blk_ff[STEP_LEFT],
                               cell_solid && !blk_ff[STEP_BACK],
                               cell_solid && !blk_ff[STEP_FRONT],
                               cell_solid && !blk_ff[STEP_BOTTOM],
                               cell_solid && !blk_ff[STEP_TOP],
                               cell_solid,
                               range_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= STEP_CENTER;
         chunk_ff     <= CHUNK_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         chunk_ff     <= chunk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      range_ff       <= range_in;
      pend_step_ff   <= pend_step_in;
      pend_inside_ff <= pend_inside_in;
      blk_ff         <= blk_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // no request is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // an accepted query starts its probe walk at the center cell
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_QUERY))
         |=> (state_ff == ST_RUN) && (step_ff == STEP_CENTER))
      else $error("query did not start probing");

   // the map is only written by the clearing pass or an accepted write
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR) || (req_fire && (req_tuser == KIND_WRITE)))
      else $error("map written outside a write transfer");

   // a visible face implies a solid, in-range cell
   a_face_needs_solid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[RSP_W-1:2] != '0)) |-> (rsp_tdata[1] && rsp_tdata[0]))
      else $error("face flagged on air or out-of-range cell");

   // a fresh response is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("stalled response overwritten");

endmodule
